FILE: rtl/tpqr_pkg.sv
// Shared types and constants of the tagged present queue.
package tpqr_pkg;

  localparam int unsigned TAG_W  = 32;
  localparam int unsigned WORD_W = 64;
  localparam int unsigned DROP_W = 4;
  localparam int unsigned TOTAL_W = 32;

  localparam logic [WORD_W-1:0] WORD_16X9 = {32'd9, 32'd16};

  localparam logic [1:0] CMD_SWAP      = 2'd0;
  localparam logic [1:0] CMD_REPRESENT = 2'd1;
  localparam logic [1:0] CMD_TAKE      = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT
  } tpqr_state_e;

  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctrl_t;

endpackage

FILE: rtl/tpqr_cell.sv
// One queue cell: holds a tag and a word, shifts toward the head and compares its tag.
module tpqr_cell
  import tpqr_pkg::*;
(
  input  logic              clk_i,
  input  cell_ctrl_t        ctrl_i,
  input  logic [TAG_W-1:0]  nbr_tag_i,
  input  logic [WORD_W-1:0] nbr_word_i,
  input  logic [TAG_W-1:0]  load_tag_i,
  input  logic [WORD_W-1:0] load_word_i,
  input  logic [TAG_W-1:0]  search_tag_i,
  output logic [TAG_W-1:0]  tag_o,
  output logic [WORD_W-1:0] word_o,
  output logic              match_o
);

  logic [TAG_W-1:0]  tag_q;
  logic [WORD_W-1:0] word_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      tag_q  <= load_tag_i;
      word_q <= load_word_i;
    end else if (ctrl_i.shift) begin
      tag_q  <= nbr_tag_i;
      word_q <= nbr_word_i;
    end
  end

  assign tag_o   = tag_q;
  assign word_o  = word_q;
  assign match_o = (tag_q == search_tag_i);

endmodule

FILE: rtl/tagged_present_queue_resync.sv
// Top level of the tagged present queue with resync counting.
//
// The input stream carries one command word per handshake: tuser holds the
// command and the emit flag, tdata the buffer tag and the latched state word.
// Push words enqueue a tag and word into a chain of cells whose head is cell
// zero; a push into a full queue shifts the oldest entry out. Push words and
// ignored words produce no output word and leave input ready high.
// A take word produces exactly one output word: the returned state word, the
// drop count and the running resync total in tdata, and the from-queue flag
// in tuser. The take scans the head cell once per cycle while the chain shifts
// by one entry, and each discarded entry is counted as a drop; at the end of
// the scan the result passes through the emit state into the output register.
// The block takes one word at a time; input ready is low during a take.
// A finished output word sits in an output register, so input is accepted
// again while it waits; a second take finishes its scan and then waits until
// the receiver takes the first word.
// Reset empties the queue, clears the resync total and restores the 16:9
// default words; the cell storage itself is not cleared.
module tagged_present_queue_resync
  import tpqr_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // buffer_tag[31:0], latched_word[95:32]
  input  logic [95:0]  s_axis_tdata,
  // cmd[1:0], emit_flag[2]
  input  logic [2:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // present_word[63:0], dropped_count[67:64], resync_total[99:68], zero pad
  output logic [103:0] m_axis_tdata,
  // from_queue[0]
  output logic [0:0]   m_axis_tuser
);

  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  tpqr_state_e state_q, state_d;

  logic [CNT_W-1:0]   count_q;
  logic [CNT_W-1:0]   drop_q;
  logic [TAG_W-1:0]   tag_q;
  logic [WORD_W-1:0]  latched_q;
  logic [WORD_W-1:0]  last_pushed_q;
  logic [WORD_W-1:0]  last_taken_q;
  logic               taken_once_q;
  logic [TOTAL_W-1:0] resync_q;
  logic [WORD_W-1:0]  res_word_q;
  logic               res_fq_q;
  logic               out_valid_q;
  logic [103:0]       out_data_q;
  logic               out_fq_q;

  logic [1:0]         in_cmd;
  logic               in_emits;
  logic [TAG_W-1:0]   in_tag;
  logic [WORD_W-1:0]  in_latched;
  logic               accept;
  logic               is_push;
  logic               is_take;
  logic               full;
  logic [WORD_W-1:0]  push_word;

  logic               empty;
  logic               any_hit;
  logic               finish_pop;
  logic               skip_pop;
  logic               emit_ok;
  logic               shift_all;
  logic [TOTAL_W:0]   resync_sum;

  cell_ctrl_t         ctrl [QUEUE_DEPTH];
  logic [TAG_W-1:0]   cell_tag [QUEUE_DEPTH];
  logic [WORD_W-1:0]  cell_word [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] cell_match;
  logic [QUEUE_DEPTH-1:0] cell_live;

  assign in_cmd     = s_axis_tuser[1:0];
  assign in_emits   = s_axis_tuser[2];
  assign in_tag     = s_axis_tdata[31:0];
  assign in_latched = s_axis_tdata[95:32];

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept    = s_axis_tvalid && s_axis_tready;
  assign is_push   = accept && in_emits && ((in_cmd == CMD_SWAP) || (in_cmd == CMD_REPRESENT));
  assign is_take   = accept && (in_cmd == CMD_TAKE);
  assign full      = (count_q == CNT_W'(QUEUE_DEPTH));
  assign push_word = (in_cmd == CMD_SWAP) ? in_latched : last_pushed_q;

  assign empty      = (count_q == '0);
  assign any_hit    = |(cell_match & cell_live);
  assign finish_pop = (state_q == ST_SCAN) && !empty && (cell_match[0] || !any_hit);
  assign skip_pop   = (state_q == ST_SCAN) && !empty && !finish_pop;
  assign emit_ok    = !out_valid_q || m_axis_tready;
  assign resync_sum = {1'b0, resync_q} + (TOTAL_W + 1)'(drop_q);

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic [TAG_W-1:0]  nbr_tag;
    logic [WORD_W-1:0] nbr_word;

    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign nbr_tag  = '0;
      assign nbr_word = '0;
    end else begin : g_body
      assign nbr_tag  = cell_tag[i+1];
      assign nbr_word = cell_word[i+1];
    end

    assign cell_live[i] = (CNT_W'(i) < count_q);

    tpqr_cell u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl[i]),
      .nbr_tag_i    (nbr_tag),
      .nbr_word_i   (nbr_word),
      .load_tag_i   (in_tag),
      .load_word_i  (push_word),
      .search_tag_i (tag_q),
      .tag_o        (cell_tag[i]),
      .word_o       (cell_word[i]),
      .match_o      (cell_match[i])
    );
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (is_take) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (empty || finish_pop) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (emit_ok) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    shift_all = (is_push && full) || finish_pop || skip_pop;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      ctrl[i].shift = shift_all;
      ctrl[i].load  = is_push &&
                      (full ? (i == QUEUE_DEPTH - 1) : (count_q == CNT_W'(i)));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      count_q       <= '0;
      last_pushed_q <= WORD_16X9;
      last_taken_q  <= WORD_16X9;
      taken_once_q  <= 1'b0;
      resync_q      <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (is_push) begin
        last_pushed_q <= push_word;
        if (!full) begin
          count_q <= count_q + CNT_W'(1);
        end
      end else if (finish_pop || skip_pop) begin
        count_q <= count_q - CNT_W'(1);
      end
      if (finish_pop) begin
        last_taken_q <= cell_word[0];
        taken_once_q <= 1'b1;
        resync_q     <= resync_sum[TOTAL_W] ? '1 : resync_sum[TOTAL_W-1:0];
      end
      if ((state_q == ST_EMIT) && emit_ok) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (is_take) begin
      tag_q     <= in_tag;
      latched_q <= in_latched;
      drop_q    <= '0;
    end else if (skip_pop) begin
      drop_q <= drop_q + CNT_W'(1);
    end
    if ((state_q == ST_SCAN) && empty) begin
      res_word_q <= taken_once_q ? last_taken_q : latched_q;
      res_fq_q   <= 1'b0;
    end else if (finish_pop) begin
      res_word_q <= cell_word[0];
      res_fq_q   <= 1'b1;
    end
    if ((state_q == ST_EMIT) && emit_ok) begin
      out_data_q <= {4'd0, resync_q, DROP_W'(drop_q), res_word_q};
      out_fq_q   <= res_fq_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_fq_q;

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(QUEUE_DEPTH))
    else $error("queue count exceeds depth");

  a_skip_keeps_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skip_pop |-> (count_q > CNT_W'(1)))
    else $error("entry discarded without a later match");

  a_total_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> (resync_q >= $past(resync_q)))
    else $error("resync total decreased");

  a_fallback_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata[67:64] == 4'd0))
    else $error("fallback word reports drops");
`endif

endmodule
